// ===== rtl/swrc_pkg.sv =====
// Shared constants and types for the sliding window replay check.
`timescale 1ns / 1ps

package swrc_pkg;

    localparam int WIN_BITS  = 8192;
    localparam int CTR_W     = 64;
    localparam int WORD_W    = 64;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int WORDS     = WIN_BITS / WORD_W;
    localparam int ADDR_W    = $clog2(WORDS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int WIN_LOG2  = $clog2(WIN_BITS);

    localparam logic [CTR_W-1:0] LIMIT_RST = 64'hFFFF_FFFF_FFFF_DFFF;

    localparam logic [1:0] VERDICT_OK    = 2'd0;
    localparam logic [1:0] VERDICT_LIMIT = 2'd1;
    localparam logic [1:0] VERDICT_OLD   = 2'd2;
    localparam logic [1:0] VERDICT_DUP   = 2'd3;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic              clr_all;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic             accepted;
        logic [1:0]       verdict;
        logic [CTR_W-1:0] highest_seen;
    } t_result;

endpackage

// ===== rtl/swrc_bitmap.sv =====
// Seen-bitmap word memory with per-word valid bits cleared at reset and on clear-all.
`timescale 1ns / 1ps

module swrc_bitmap
    import swrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_req          i_req,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [WORDS];
    logic [WORDS-1:0]  r_valid;
    logic [WORD_W-1:0] r_rdata;
    logic              r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rvalid <= r_valid[i_req.addr];
            end
            if (i_req.clr_all) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.addr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// ===== rtl/swrc_seq.sv =====
// Check sequencer: limit and age tests, window slide and bit test-and-set.
`timescale 1ns / 1ps

module swrc_seq
    import swrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CTR_W-1:0]  i_rx_counter,
    input  logic [CTR_W-1:0]  i_limit,
    output t_mem_req          o_req,
    input  logic [WORD_W-1:0] i_rdata,
    input  logic              i_out_free,
    output logic              o_push,
    output t_result           o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_PLAN,
        S_STEP,
        S_WR,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [CTR_W-1:0]   r_rx;
    logic [CTR_W-1:0]   r_high;
    logic [1:0]         r_verdict;
    logic               r_adv;
    logic [ADDR_W-1:0]  r_addr;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_first;
    logic               r_noclr;
    logic [BIT_W-1:0]   r_lo;
    logic [BIT_W-1:0]   r_hi;
    logic [BIT_W-1:0]   r_bit;

    logic                    w_over;
    logic                    w_old;
    logic [CTR_W-1:0]        w_high_m_win;
    logic [CTR_W-1:0]        w_dist;
    logic                    w_big;
    logic [BIT_W+CNT_W-1:0]  w_hp1;
    logic [CNT_W-1:0]        w_span;
    logic                    w_last;
    logic [BIT_W-1:0]        w_lo;
    logic [BIT_W-1:0]        w_hi;
    logic [WORD_W-1:0]       w_clr;
    logic [WORD_W-1:0]       w_set;
    logic                    w_direct;
    logic                    w_dup;

    function automatic logic [WORD_W-1:0] f_range(input logic [BIT_W-1:0] lo,
                                                  input logic [BIT_W-1:0] hi);
        logic [WORD_W-1:0] ones;
        ones = '1;
        return (ones << lo) & (ones >> (BIT_W'(WORD_W - 1) - hi));
    endfunction

    always_comb begin
        w_high_m_win = r_high - CTR_W'(WIN_BITS);
        w_over = (r_rx >= i_limit);
        w_old  = (|r_high[CTR_W-1:WIN_LOG2]) && (r_rx <= w_high_m_win);
        w_dist = r_rx - r_high;
        w_big  = |w_dist[CTR_W-1:WIN_LOG2];
        w_hp1  = r_high[BIT_W+CNT_W-1:0] + (BIT_W+CNT_W)'(1);
        w_span = r_rx[BIT_W +: CNT_W] - w_hp1[BIT_W +: CNT_W];

        w_last   = (r_cnt == '0);
        w_lo     = r_first ? r_lo : '0;
        w_hi     = w_last ? r_hi : BIT_W'(WORD_W - 1);
        w_clr    = r_noclr ? '0 : f_range(w_lo, w_hi);
        w_set    = w_last ? (WORD_W'(1) << r_bit) : '0;
        w_direct = (w_clr == '1);
        w_dup    = r_noclr && i_rdata[r_bit];

        o_req.addr    = r_addr;
        o_req.rd_en   = (r_state == S_STEP) && !w_direct;
        o_req.wr_en   = ((r_state == S_STEP) && w_direct) || ((r_state == S_WR) && !w_dup);
        o_req.clr_all = (r_state == S_PLAN) && r_adv && w_big;
        o_req.wdata   = w_direct ? w_set : ((i_rdata & ~w_clr) | w_set);

        o_in_ready = (r_state == S_IDLE);
        o_push     = (r_state == S_DONE) && i_out_free;
        o_res.accepted     = (r_verdict == VERDICT_OK);
        o_res.verdict      = r_verdict;
        o_res.highest_seen = r_high;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_high    <= '0;
            r_verdict <= VERDICT_OK;
            r_adv     <= 1'b0;
            r_cnt     <= '0;
            r_first   <= 1'b0;
            r_noclr   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_rx    <= i_rx_counter;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_adv <= (r_rx > r_high);
                    if (w_over) begin
                        r_verdict <= VERDICT_LIMIT;
                        r_state   <= S_DONE;
                    end else if (w_old) begin
                        r_verdict <= VERDICT_OLD;
                        r_state   <= S_DONE;
                    end else begin
                        r_verdict <= VERDICT_OK;
                        r_state   <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    r_bit   <= r_rx[BIT_W-1:0];
                    r_first <= 1'b1;
                    r_state <= S_STEP;
                    if (!r_adv) begin
                        r_addr  <= r_rx[BIT_W +: ADDR_W];
                        r_cnt   <= '0;
                        r_noclr <= 1'b1;
                        r_lo    <= '0;
                        r_hi    <= '0;
                    end else if (w_big) begin
                        r_addr  <= r_rx[BIT_W +: ADDR_W];
                        r_cnt   <= '0;
                        r_noclr <= 1'b0;
                        r_lo    <= '0;
                        r_hi    <= BIT_W'(WORD_W - 1);
                        r_high  <= r_rx;
                    end else begin
                        r_addr  <= w_hp1[BIT_W +: ADDR_W];
                        r_cnt   <= w_span;
                        r_noclr <= 1'b0;
                        r_lo    <= w_hp1[BIT_W-1:0];
                        r_hi    <= r_rx[BIT_W-1:0];
                        r_high  <= r_rx;
                    end
                end
                S_STEP: begin
                    if (!w_direct) begin
                        r_state <= S_WR;
                    end else if (w_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_addr  <= r_addr + ADDR_W'(1);
                        r_cnt   <= r_cnt - CNT_W'(1);
                        r_first <= 1'b0;
                    end
                end
                S_WR: begin
                    if (w_dup) begin
                        r_verdict <= VERDICT_DUP;
                        r_state   <= S_DONE;
                    end else if (w_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_addr  <= r_addr + ADDR_W'(1);
                        r_cnt   <= r_cnt - CNT_W'(1);
                        r_first <= 1'b0;
                        r_state <= S_STEP;
                    end
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/sliding_window_replay_check.sv =====
// Top level of the sliding window replay check.
`timescale 1ns / 1ps

// Checks the 64-bit counter of each received word against the reject limit
// and an 8192-counter replay window, and returns one result word per input
// word: accepted flag, verdict and the highest counter after the check. The
// window is kept as 128 words of 64 bits in a one-port synchronous memory,
// indexed by the counter modulo the window; per-word valid bits clear it at
// reset and on a jump of a whole window or more, so there is no clearing
// pass. One word is handled at a time. A rejected counter goes straight to
// the result; a counter at or below the highest does one read-modify-write
// of its memory word; a jump of a whole window or more clears the valid
// bits and writes its word directly. A smaller jump writes each wholly passed
// memory word directly and read-modify-writes each partly passed word at
// either end. The memory port takes one access per cycle. A new input word
// is taken while a finished result waits in the output register.
module sliding_window_replay_check
    import swrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,   // reject_limit
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,     // [63:0] rx_counter
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata      // [0] accepted, [2:1] verdict, [66:3] highest_seen
);

    logic [CTR_W-1:0]  r_limit;
    logic              r_ovalid;
    t_result           r_ores;
    t_mem_req          w_req;
    logic [WORD_W-1:0] w_rdata;
    logic              w_free;
    logic              w_push;
    t_result           w_res;

    assign w_free = !r_ovalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RST;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (w_push) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ores <= w_res;
        end
    end

    swrc_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_tvalid),
        .o_in_ready   (o_s_tready),
        .i_rx_counter (i_s_tdata),
        .i_limit      (r_limit),
        .o_req        (w_req),
        .i_rdata      (w_rdata),
        .i_out_free   (w_free),
        .o_push       (w_push),
        .o_res        (w_res)
    );

    swrc_bitmap u_bitmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'd0, r_ores.highest_seen, r_ores.verdict, r_ores.accepted};

endmodule
